// ===== rtl/gregh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gregh_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 13;
  localparam int HOURS_W = 35;

  // year shifted by 400 so the march-based year never goes negative
  localparam int YADJ_W      = 15;
  localparam int EPOCH_YEARS = 400;
  localparam int Q4_W        = YADJ_W - 2;
  localparam int MOFF_W      = 9;
  localparam int MD_W        = 10;
  localparam int DN_W        = 23;
  localparam int DD_W        = DN_W + 1;
  localparam int HD_W        = HOUR_W + 1;
  localparam int DIFF_W      = 38;

  // y/100 as (y/4)/25, /25 by reciprocal: exact for y/4 below 2^17/3
  localparam int RECIP_25    = 5243;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = 25;
  localparam int Q100_W      = PROD_W - RECIP_SHIFT;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    begin
      if (m < MONTH_JAN) r = MONTH_JAN;
      else if (m > MONTH_DEC) r = MONTH_DEC;
      else r = m;
      return r;
    end
  endfunction

  // days before the month in a year that starts in march
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [MOFF_W-1:0] r;
    begin
      case (m)
        4'd3:    r = 9'd0;
        4'd4:    r = 9'd31;
        4'd5:    r = 9'd61;
        4'd6:    r = 9'd92;
        4'd7:    r = 9'd122;
        4'd8:    r = 9'd153;
        4'd9:    r = 9'd184;
        4'd10:   r = 9'd214;
        4'd11:   r = 9'd245;
        4'd12:   r = 9'd275;
        4'd1:    r = 9'd306;
        4'd2:    r = 9'd337;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gregh_day_num.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gregh_day_num
  import gregh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [YEAR_W-1:0]  year,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [DAY_W-1:0]   day,
  output logic      [DN_W-1:0]    dn
);

  logic [MONTH_W-1:0] m_c;
  logic [YADJ_W-1:0]  y_next;
  logic [MD_W-1:0]    md_next;

  // stage 1
  logic [YADJ_W-1:0] y1;
  logic [MD_W-1:0]   md1;
  // stage 2
  logic [Q4_W-1:0]   q4_2;
  logic [PROD_W-1:0] prod2;
  logic [DN_W-1:0]   y365_2;
  logic [MD_W-1:0]   md2;

  logic [Q100_W-1:0] q100;
  logic [DN_W-1:0]   dn_next;

  always_comb begin
    m_c = clamp_month(month);
    y_next = YADJ_W'(year) + YADJ_W'(EPOCH_YEARS);
    // january and february belong to the previous march-based year
    if (m_c <= MONTH_FEB) y_next = y_next - YADJ_W'(1);
    md_next = MD_W'(month_offset(m_c)) + MD_W'(day);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1  <= y_next;
      md1 <= md_next;
      q4_2   <= y1[YADJ_W-1:2];
      prod2  <= PROD_W'(y1[YADJ_W-1:2]) * PROD_W'(RECIP_25);
      y365_2 <= DN_W'(y1) * DN_W'(365);
      md2    <= md1;
      dn <= dn_next;
    end
  end

  always_comb begin
    q100 = prod2[PROD_W-1:RECIP_SHIFT];
    dn_next = y365_2 + DN_W'(q4_2) - DN_W'(q100) + DN_W'(q100[Q100_W-1:2])
              + DN_W'(md2);
  end

endmodule

`default_nettype wire

// ===== rtl/gregorian_hours_between_dates.sv =====
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle while no stalled result is held, five register stages with a common advance enable
// day numbers come from two three-stage closed-form units, then difference and scaling
// rst clears all valid bits; payload registers are not reset

module gregorian_hours_between_dates
  import gregh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               dates_valid,
  output logic                    dates_stall,
  input  wire logic [YEAR_W-1:0]  start_year,
  input  wire logic [MONTH_W-1:0] start_month,
  input  wire logic [DAY_W-1:0]   start_day,
  input  wire logic [HOUR_W-1:0]  start_hour,
  input  wire logic [YEAR_W-1:0]  end_year,
  input  wire logic [MONTH_W-1:0] end_month,
  input  wire logic [DAY_W-1:0]   end_day,
  input  wire logic [HOUR_W-1:0]  end_hour,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    order_error,
  output logic      [HOURS_W-1:0] hours_between
);

  localparam int DN_STAGES = 3;

  logic en;
  logic [DN_W-1:0] dn_s;
  logic [DN_W-1:0] dn_e;

  logic [MONTH_W-1:0] ms_c;
  logic [MONTH_W-1:0] me_c;
  logic               after_next;
  logic [HD_W-1:0]    hd_next;

  logic [DN_STAGES-1:0] v_pipe;
  logic [DN_STAGES-1:0] after_pipe;
  logic [HD_W-1:0]      hd_pipe [DN_STAGES];

  logic              v4;
  logic              after4;
  logic [HD_W-1:0]   hd4;
  logic [DD_W-1:0]   dd4;

  logic [DIFF_W-1:0] diff;
  logic              err_next;
  logic [HOURS_W-1:0] hours_next;

  assign en = !(result_valid && result_stall);
  assign dates_stall = !en;

  gregh_day_num u_dn_start (
    .clk   (clk),
    .en    (en),
    .year  (start_year),
    .month (start_month),
    .day   (start_day),
    .dn    (dn_s)
  );

  gregh_day_num u_dn_end (
    .clk   (clk),
    .en    (en),
    .year  (end_year),
    .month (end_month),
    .day   (end_day),
    .dn    (dn_e)
  );

  always_comb begin
    ms_c = clamp_month(start_month);
    me_c = clamp_month(end_month);
    after_next = {start_year, ms_c, start_day, start_hour} >
                 {end_year, me_c, end_day, end_hour};
    hd_next = HD_W'(end_hour) - HD_W'(start_hour);
  end

  // order flag and hour difference ride alongside the day number units
  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe <= '0;
      v4 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v_pipe <= {v_pipe[DN_STAGES-2:0], dates_valid};
      v4 <= v_pipe[DN_STAGES-1];
      result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      after_pipe <= {after_pipe[DN_STAGES-2:0], after_next};
      hd_pipe[0] <= hd_next;
      for (int i = 1; i < DN_STAGES; i++) begin
        hd_pipe[i] <= hd_pipe[i-1];
      end
      after4 <= after_pipe[DN_STAGES-1];
      hd4    <= hd_pipe[DN_STAGES-1];
      dd4    <= DD_W'(dn_e) - DD_W'(dn_s);
      order_error   <= err_next;
      hours_between <= hours_next;
    end
  end

  // 6144 units per day = (dd << 12) + (dd << 11)
  always_comb begin
    diff = ({{(DIFF_W-DD_W){dd4[DD_W-1]}}, dd4} << 12)
         + ({{(DIFF_W-DD_W){dd4[DD_W-1]}}, dd4} << 11)
         + {{(DIFF_W-HD_W){hd4[HD_W-1]}}, hd4};
    if (after4 || diff[DIFF_W-1]) begin
      err_next = 1'b1;
      hours_next = '0;
    end else if (diff[DIFF_W-2:HOURS_W] != '0) begin
      err_next = 1'b0;
      hours_next = '1;
    end else begin
      err_next = 1'b0;
      hours_next = diff[HOURS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== bench/gregorian_hours_between_dates_checker.sv =====
`timescale 1ns / 1ps

module gregorian_hours_between_dates_checker
  import gregh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               dates_valid,
  input  logic               dates_stall,
  input  logic [YEAR_W-1:0]  start_year,
  input  logic [MONTH_W-1:0] start_month,
  input  logic [DAY_W-1:0]   start_day,
  input  logic [HOUR_W-1:0]  start_hour,
  input  logic [YEAR_W-1:0]  end_year,
  input  logic [MONTH_W-1:0] end_month,
  input  logic [DAY_W-1:0]   end_day,
  input  logic [HOUR_W-1:0]  end_hour,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic               order_error,
  input  logic [HOURS_W-1:0] hours_between,
  output int                 failures,
  output int                 pending
);

  typedef struct {
    logic               bad_order;
    logic [HOURS_W-1:0] hours;
  } span_t;

  // one day in 1/256-hour units
  localparam longint DAY_UNITS  = 24 * 256;
  localparam longint HOURS_CEIL = (longint'(1) << HOURS_W) - 1;

  span_t expected_spans[$];

  function automatic logic [MONTH_W-1:0] month_in_range(input logic [MONTH_W-1:0] m);
    if (m < MONTH_JAN) return MONTH_JAN;
    if (m > MONTH_DEC) return MONTH_DEC;
    return m;
  endfunction

  // march-based day count, year shifted by 400 so it stays positive
  function automatic longint serial_day(input logic [YEAR_W-1:0] y,
                                        input logic [MONTH_W-1:0] m,
                                        input logic [DAY_W-1:0] d);
    longint yy;
    longint mp;
    yy = longint'(y) + 400;
    if (m <= MONTH_FEB) begin
      yy = yy - 1;
      mp = longint'(m) + 9;
    end else begin
      mp = longint'(m) - 3;
    end
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + longint'(d);
  endfunction

  function automatic span_t hours_span(
    input logic [YEAR_W-1:0] s_year, input logic [MONTH_W-1:0] s_month_raw,
    input logic [DAY_W-1:0] s_day, input logic [HOUR_W-1:0] s_hour,
    input logic [YEAR_W-1:0] e_year, input logic [MONTH_W-1:0] e_month_raw,
    input logic [DAY_W-1:0] e_day, input logic [HOUR_W-1:0] e_hour);
    logic [MONTH_W-1:0] s_month;
    logic [MONTH_W-1:0] e_month;
    logic               after;
    longint             diff;
    span_t              r;
    s_month = month_in_range(s_month_raw);
    e_month = month_in_range(e_month_raw);
    if (s_year != e_year) after = s_year > e_year;
    else if (s_month != e_month) after = s_month > e_month;
    else if (s_day != e_day) after = s_day > e_day;
    else after = s_hour > e_hour;
    diff = (serial_day(e_year, e_month, e_day) - serial_day(s_year, s_month, s_day))
           * DAY_UNITS + longint'(e_hour) - longint'(s_hour);
    // odd days or hours can push the difference negative past the order test
    if (after || diff < 0) begin
      r.bad_order = 1'b1;
      r.hours     = '0;
    end else begin
      r.bad_order = 1'b0;
      r.hours     = (diff > HOURS_CEIL) ? '1 : diff[HOURS_W-1:0];
    end
    return r;
  endfunction

  initial failures = 0;

  always @(posedge clk) begin
    span_t want;
    if (rst) begin
      pending <= 0;
    end else begin
      if (dates_valid && !dates_stall)
        expected_spans.push_back(hours_span(start_year, start_month, start_day, start_hour,
                                            end_year, end_month, end_day, end_hour));
      if (result_valid && !result_stall) begin
        if (expected_spans.size() == 0) begin
          failures++;
          $error("result with no item waiting: order_error %0d hours_between %0d",
                 order_error, hours_between);
        end else begin
          want = expected_spans.pop_front();
          if (order_error !== want.bad_order) begin
            failures++;
            $error("order_error: expected %0d, actual %0d", want.bad_order, order_error);
          end
          if (hours_between !== want.hours) begin
            failures++;
            $error("hours_between: expected %0d, actual %0d", want.hours, hours_between);
          end
        end
      end
      pending <= expected_spans.size();
    end
  end

endmodule

// ===== bench/gregorian_hours_between_dates_tb.sv =====
`timescale 1ns / 1ps

module gregorian_hours_between_dates_tb;
  import gregh_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int CALM_AFTER      = 1500;
  localparam int LONG_HOLD_AT    = 300;
  localparam int LONG_HOLD_TICKS = 120;
  localparam int YEAR_TOP        = (1 << YEAR_W) - 1;

  typedef struct packed {
    logic [YEAR_W-1:0]  s_year;
    logic [MONTH_W-1:0] s_month;
    logic [DAY_W-1:0]   s_day;
    logic [HOUR_W-1:0]  s_hour;
    logic [YEAR_W-1:0]  e_year;
    logic [MONTH_W-1:0] e_month;
    logic [DAY_W-1:0]   e_day;
    logic [HOUR_W-1:0]  e_hour;
  } date_pair_t;

  logic               clk;
  logic               rst;
  logic               dates_valid;
  logic               dates_stall;
  logic [YEAR_W-1:0]  start_year;
  logic [MONTH_W-1:0] start_month;
  logic [DAY_W-1:0]   start_day;
  logic [HOUR_W-1:0]  start_hour;
  logic [YEAR_W-1:0]  end_year;
  logic [MONTH_W-1:0] end_month;
  logic [DAY_W-1:0]   end_day;
  logic [HOUR_W-1:0]  end_hour;
  logic               result_valid;
  logic               result_stall;
  logic               order_error;
  logic [HOURS_W-1:0] hours_between;

  int failures;
  int pending;
  int items_sent;
  bit calm;

  gregorian_hours_between_dates dut (.*);

  gregorian_hours_between_dates_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic date_pair_t make_pair(input int sy, input int sm, input int sd,
                                           input int sh, input int ey, input int em,
                                           input int ed, input int eh);
    date_pair_t p;
    p.s_year  = YEAR_W'(sy);
    p.s_month = MONTH_W'(sm);
    p.s_day   = DAY_W'(sd);
    p.s_hour  = HOUR_W'(sh);
    p.e_year  = YEAR_W'(ey);
    p.e_month = MONTH_W'(em);
    p.e_day   = DAY_W'(ed);
    p.e_hour  = HOUR_W'(eh);
    return p;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int         kind;
    int         y;
    kind = $urandom_range(0, 99);
    p.s_year  = YEAR_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, YEAR_TOP)
                                                     : $urandom_range(0, 9999));
    p.s_month = MONTH_W'($urandom_range(1, 12));
    p.s_day   = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
                                                   : $urandom_range(1, 28));
    p.s_hour  = HOUR_W'($urandom_range(0, 6144));
    p.e_month = MONTH_W'($urandom_range(1, 12));
    p.e_day   = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
                                                   : $urandom_range(1, 28));
    p.e_hour  = HOUR_W'($urandom_range(0, 6144));
    y = p.s_year + $urandom_range(0, 3);
    p.e_year  = YEAR_W'((y > YEAR_TOP) ? YEAR_TOP : y);
    if (kind < 15) begin
      // raw bits, out-of-range months, days and hours included
      p.s_year  = YEAR_W'($urandom);
      p.s_month = MONTH_W'($urandom);
      p.s_day   = DAY_W'($urandom);
      p.s_hour  = HOUR_W'($urandom);
      p.e_year  = YEAR_W'($urandom);
      p.e_month = MONTH_W'($urandom);
      p.e_day   = DAY_W'($urandom);
      p.e_hour  = HOUR_W'($urandom);
    end else if (kind < 30) begin
      p.e_year  = p.s_year;
      p.e_month = p.s_month;
      p.e_day   = p.s_day;
    end else if (kind < 40) begin
      p.e_year = YEAR_W'($urandom_range(int'(p.s_year), YEAR_TOP));
    end else if (kind < 50) begin
      // start and end halves swapped: mostly reversed order
      p = {p[$bits(p)/2-1:0], p[$bits(p)-1:$bits(p)/2]};
    end else if (kind < 60) begin
      p.e_year  = p.s_year;
      p.e_month = p.s_month;
    end
    return p;
  endfunction

  task automatic offer(input date_pair_t p);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      dates_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start_year  <= p.s_year;
    start_month <= p.s_month;
    start_day   <= p.s_day;
    start_hour  <= p.s_hour;
    end_year    <= p.e_year;
    end_month   <= p.e_month;
    end_day     <= p.e_day;
    end_hour    <= p.e_hour;
    dates_valid <= 1'b1;
    do @(posedge clk); while (dates_stall);
    items_sent++;
  endtask

  // result side: random stall bursts plus one long hold-off to back the pipe up
  initial begin : result_side
    int  hold;
    bit  long_hold_done;
    hold = 0;
    long_hold_done = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
        long_hold_done = 1;
        hold = LONG_HOLD_TICKS;
      end else if (hold == 0 && !calm && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(1, 13);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int i;
    rst         = 1'b1;
    dates_valid = 1'b0;
    start_year  = '0;
    start_month = '0;
    start_day   = '0;
    start_hour  = '0;
    end_year    = '0;
    end_month   = '0;
    end_day     = '0;
    end_hour    = '0;
    calm        = 0;
    items_sent  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    offer(make_pair(2023, 6, 15, 12*256, 2023, 6, 15, 12*256));
    offer(make_pair(2023, 6, 15, 12*256 + 1, 2023, 6, 15, 12*256));
    // leap rules: year 0, century, 400-year
    offer(make_pair(0, 2, 28, 0, 0, 3, 1, 0));
    offer(make_pair(1900, 2, 28, 0, 1900, 3, 1, 0));
    offer(make_pair(2000, 2, 28, 0, 2000, 3, 1, 0));
    offer(make_pair(2100, 2, 28, 0, 2100, 3, 1, 0));
    offer(make_pair(2024, 2, 29, 100, 2025, 2, 28, 200));
    // month clamping
    offer(make_pair(2020, 0, 5, 0, 2020, 1, 5, 0));
    offer(make_pair(2020, 15, 1, 0, 2020, 12, 1, 0));
    offer(make_pair(2020, 13, 1, 0, 2020, 11, 30, 0));
    // days past the month end or zero
    offer(make_pair(2021, 4, 31, 0, 2021, 5, 1, 0));
    offer(make_pair(2021, 3, 0, 0, 2021, 3, 1, 0));
    offer(make_pair(2021, 2, 31, 0, 2021, 3, 1, 0));
    // hours past 24.0
    offer(make_pair(2021, 7, 4, 8191, 2021, 7, 5, 0));
    offer(make_pair(2021, 7, 4, 0, 2021, 7, 4, 8191));
    offer(make_pair(1999, 12, 31, 6143, 2000, 1, 1, 0));
    // widest spans and saturation
    offer(make_pair(0, 1, 1, 0, 9999, 12, 31, 6144));
    offer(make_pair(0, 1, 1, 0, YEAR_TOP, 12, 31, 8191));
    offer(make_pair(0, 0, 0, 0, YEAR_TOP, 15, 31, 8191));
    // reversed order at the year, month and day fields, and all-ones dates
    offer(make_pair(9999, 12, 31, 0, 0, 1, 1, 0));
    offer(make_pair(2023, 11, 2, 0, 2023, 10, 30, 0));
    offer(make_pair(2023, 11, 2, 0, 2023, 11, 1, 6000));
    offer(make_pair(YEAR_TOP, 15, 31, 8191, YEAR_TOP, 15, 31, 8191));
    offer(make_pair(YEAR_TOP, 15, 31, 8191, 0, 0, 0, 0));

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= CALM_AFTER) calm = 1;
      offer(random_pair());
    end
    @(negedge clk);
    dates_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
